>>> rtl/core/htb_pkg.sv
`default_nettype none

package htb_pkg;

  // Image geometry and sample format
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int COL_BITS      = $clog2(MAX_ROW_WIDTH);
  localparam int RW_BITS       = 13;
  localparam int PIXEL_BITS    = 16;
  localparam int WEIGHT_BITS   = 8;
  localparam int CFG_BITS      = 13;
  localparam int CFG_IDX_BITS  = 2;

  // Accumulator and divider sizes
  localparam int PROD_BITS = PIXEL_BITS + WEIGHT_BITS;
  localparam int ACC_BITS  = PROD_BITS + 1;
  localparam int MAG_BITS  = PROD_BITS;
  localparam int WSUM_BITS = WEIGHT_BITS + 2;
  localparam int DVS_BITS  = WEIGHT_BITS + 1;
  localparam int DIV_STEPS = MAG_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  // Saturation limits of a result sample
  localparam int PIX_MAX = (1 << (PIXEL_BITS - 1)) - 1;
  localparam int PIX_MIN_MAG = 1 << (PIXEL_BITS - 1);

  // Register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_WIDTH     = 2'd0,
    REG_LEFT_WEIGHT   = 2'd1,
    REG_CENTER_WEIGHT = 2'd2,
    REG_RIGHT_WEIGHT  = 2'd3
  } cfg_reg_t;

  // Tap picked by the multiply-accumulate step
  typedef enum logic [1:0] {
    TAP_L = 2'd0,
    TAP_C = 2'd1,
    TAP_R = 2'd2
  } tap_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     accept;
    logic     load_b;
    logic     mac_en;
    tap_sel_t mac_sel;
    logic     div_load;
    logic     div_step;
    logic     finish;
  } htb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic first;
    logic last;
  } htb_status_t;

endpackage

`default_nettype wire

>>> rtl/core/htb_datapath.sv
`default_nettype none

module htb_datapath
  import htb_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [CFG_BITS-1:0]          cfg_data,
  input  wire logic signed [PIXEL_BITS-1:0] pixel_in,
  input  wire htb_cmd_t                     cmd,
  output htb_status_t                       status,
  output logic signed [PIXEL_BITS-1:0]      pixel_out,
  output logic                              clipped,
  output logic                              zero_divisor
);

  logic [RW_BITS-1:0]            row_width;
  logic signed [WEIGHT_BITS-1:0] left_weight;
  logic signed [WEIGHT_BITS-1:0] center_weight;
  logic signed [WEIGHT_BITS-1:0] right_weight;

  logic signed [PIXEL_BITS-1:0] older_pixel;
  logic signed [PIXEL_BITS-1:0] newer_pixel;
  logic [COL_BITS-1:0]          column_count;
  logic [COL_BITS-1:0]          last_col;

  logic signed [PIXEL_BITS-1:0]  tap_l;
  logic signed [PIXEL_BITS-1:0]  tap_c;
  logic signed [PIXEL_BITS-1:0]  tap_r;
  logic signed [PIXEL_BITS-1:0]  mac_tap;
  logic signed [WEIGHT_BITS-1:0] mac_weight;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [WSUM_BITS-1:0]   wsum;

  logic                neg;
  logic [MAG_BITS-1:0] dvd;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS+1:0] trial;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= RW_BITS'(64);
      left_weight   <= WEIGHT_BITS'(1);
      center_weight <= WEIGHT_BITS'(2);
      right_weight  <= WEIGHT_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH:     row_width     <= cfg_data[RW_BITS-1:0];
        REG_LEFT_WEIGHT:   left_weight   <= cfg_data[WEIGHT_BITS-1:0];
        REG_CENTER_WEIGHT: center_weight <= cfg_data[WEIGHT_BITS-1:0];
        REG_RIGHT_WEIGHT:  right_weight  <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the row width and find the last column
  always_comb begin
    if (row_width == '0) begin
      last_col = '0;
    end else if (row_width > RW_BITS'(MAX_ROW_WIDTH)) begin
      last_col = COL_BITS'(MAX_ROW_WIDTH - 1);
    end else begin
      last_col = COL_BITS'(row_width - RW_BITS'(1));
    end
  end

  assign status.first = (column_count == '0);
  assign status.last  = (column_count >= last_col);

  // Advance the column counter and pixel history
  always_ff @(posedge clk) begin
    if (rst) begin
      older_pixel  <= '0;
      newer_pixel  <= '0;
      column_count <= '0;
    end else if (cmd.accept) begin
      if (status.first) begin
        older_pixel <= '0;
      end else begin
        older_pixel <= newer_pixel;
      end
      newer_pixel <= pixel_in;
      if (status.last) begin
        column_count <= '0;
      end else begin
        column_count <= column_count + COL_BITS'(1);
      end
    end
  end

  // Tap window for the result being computed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (status.first) begin
        tap_l <= '0;
        tap_c <= pixel_in;
        tap_r <= '0;
      end else begin
        tap_l <= older_pixel;
        tap_c <= newer_pixel;
        tap_r <= pixel_in;
      end
    end else if (cmd.load_b) begin
      tap_l <= older_pixel;
      tap_c <= newer_pixel;
      tap_r <= '0;
    end
  end

  // One tap times its weight per cycle
  always_comb begin
    case (cmd.mac_sel)
      TAP_L: begin
        mac_tap    = tap_l;
        mac_weight = left_weight;
      end
      TAP_C: begin
        mac_tap    = tap_c;
        mac_weight = center_weight;
      end
      TAP_R: begin
        mac_tap    = tap_r;
        mac_weight = right_weight;
      end
      default: begin
        mac_tap    = '0;
        mac_weight = '0;
      end
    endcase
  end

  assign prod = mac_tap * mac_weight;
  assign wsum = WSUM_BITS'(left_weight) + WSUM_BITS'(center_weight)
              + WSUM_BITS'(right_weight);

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      if (cmd.mac_sel == TAP_L) begin
        acc <= ACC_BITS'(prod);
      end else begin
        acc <= acc + ACC_BITS'(prod);
      end
    end
  end

  // Restoring divide on magnitudes, one quotient bit per cycle
  assign trial = {1'b0, rem, dvd[MAG_BITS-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg <= acc[ACC_BITS-1] ^ wsum[WSUM_BITS-1];
      dvd <= acc[ACC_BITS-1] ? MAG_BITS'(-acc) : acc[MAG_BITS-1:0];
      dvs <= wsum[WSUM_BITS-1] ? DVS_BITS'(-wsum) : wsum[DVS_BITS-1:0];
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!trial[DVS_BITS+1]) begin
        rem <= trial[DVS_BITS-1:0];
        dvd <= {dvd[MAG_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[DVS_BITS-2:0], dvd[MAG_BITS-1]};
        dvd <= {dvd[MAG_BITS-2:0], 1'b0};
      end
    end
  end

  // Apply sign, saturate (or flag a zero divisor), and hold the result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (wsum == '0) begin
        pixel_out    <= '0;
        clipped      <= 1'b0;
        zero_divisor <= 1'b1;
      end else if (!neg) begin
        zero_divisor <= 1'b0;
        if (dvd > MAG_BITS'(PIX_MAX)) begin
          pixel_out <= PIXEL_BITS'(PIX_MAX);
          clipped   <= 1'b1;
        end else begin
          pixel_out <= dvd[PIXEL_BITS-1:0];
          clipped   <= 1'b0;
        end
      end else begin
        zero_divisor <= 1'b0;
        if (dvd > MAG_BITS'(PIX_MIN_MAG)) begin
          pixel_out <= PIXEL_BITS'(PIX_MIN_MAG);
          clipped   <= 1'b1;
        end else begin
          pixel_out <= PIXEL_BITS'(-dvd[PIXEL_BITS-1:0]);
          clipped   <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/htb_ctrl.sv
`default_nettype none

module htb_ctrl
  import htb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire htb_status_t status,
  output htb_cmd_t         cmd,
  output logic             row_end,
  output logic             run_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DLOAD,
    ST_DIV,
    ST_FIN,
    ST_OUT,
    ST_LOADB
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] cnt;
  logic                is_b;
  logic                last_q;

  // Sequencer: state, step counter and row flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      is_b   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (!(status.first && !status.last)) begin
              is_b   <= status.first;
              last_q <= status.last;
              cnt    <= '0;
              state  <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          if (cnt == CNT_BITS'(TAP_R)) begin
            state <= ST_DLOAD;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        ST_DLOAD: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == CNT_BITS'(DIV_STEPS - 1)) begin
            state <= ST_FIN;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        ST_FIN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (!is_b && last_q) begin
              state <= ST_LOADB;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_LOADB: begin
          is_b  <= 1'b1;
          cnt   <= '0;
          state <= ST_MAC;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Decode datapath commands
  always_comb begin
    cmd          = '0;
    cmd.mac_sel  = tap_sel_t'(cnt[1:0]);
    cmd.accept   = (state == ST_IDLE) && in_valid;
    cmd.load_b   = (state == ST_LOADB);
    cmd.mac_en   = (state == ST_MAC);
    cmd.div_load = (state == ST_DLOAD);
    cmd.div_step = (state == ST_DIV);
    cmd.finish   = (state == ST_FIN);
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign row_end   = is_b;
  assign run_last  = is_b || !last_q;

`ifndef ASSERT_OFF
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

  a_row_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && row_end) |-> run_last)
    else $error("row end result not marked last of its run");

  a_first_pixel_no_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.first && !status.last) |=> (state == ST_IDLE))
    else $error("first pixel of a row started a result");

  a_div_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < CNT_BITS'(DIV_STEPS)))
    else $error("divide step counter out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/horizontal_three_tap_blur.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    pixel_in
// output    out_valid / out_stall  pixel_out, row_end, run_last, clipped, zero_divisor
// config    cfg_we                 cfg_index, cfg_data
//
// One request is taken at a time; the first pixel of a wider row starts no result.
// With out_stall low, each result steps through accept, multiply-accumulate (one shared
// multiplier), divider load, divide steps (bit-serial divider), finish and output. A row's
// last pixel, unless also its first, runs the sequence twice; a tap reload replaces the
// second accept. rst is synchronous: configuration returns to its defaults and the row restarts.
// in_stall is high from a result's accept until the last result is taken; out_stall holds it.
`default_nettype none

module horizontal_three_tap_blur
  import htb_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [CFG_BITS-1:0]          cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [PIXEL_BITS-1:0] pixel_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [PIXEL_BITS-1:0]      pixel_out,
  output logic                              row_end,
  output logic                              run_last,
  output logic                              clipped,
  output logic                              zero_divisor
);

  htb_cmd_t    cmd;
  htb_status_t status;

  htb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .row_end   (row_end),
    .run_last  (run_last)
  );

  htb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_in     (pixel_in),
    .cmd          (cmd),
    .status       (status),
    .pixel_out    (pixel_out),
    .clipped      (clipped),
    .zero_divisor (zero_divisor)
  );

endmodule

`default_nettype wire
